@@ rtl/pdc_pkg.sv @@
// Types, codes and constants for the pixel difference classifier.
// Used by the channel interfaces and all RTL modules; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pdc_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BELOW_COLOUR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ABOVE_COLOUR = 2'd2;

  localparam logic [7:0] TOLERANCE_RST = 8'd0;
  localparam logic [23:0] BELOW_COLOUR_RST = 24'd205;
  localparam logic [23:0] ABOVE_COLOUR_RST = 24'd13434880;

  // BT.601 luma weights in unsigned 0.16 fixed point, truncated.
  localparam logic [15:0] GRAY_COEF_R = 16'd19595;
  localparam logic [15:0] GRAY_COEF_G = 16'd38469;
  localparam logic [15:0] GRAY_COEF_B = 16'd7471;

  localparam logic [7:0] OUT_ALPHA_VALUE = 8'd255;

  typedef enum logic [1:0] {
    CLS_IDENTICAL = 2'd0,
    CLS_BELOW     = 2'd1,
    CLS_ABOVE     = 2'd2
  } pdc_class_t;

  typedef struct packed {
    logic [7:0] left_blue;
    logic [7:0] left_green;
    logic [7:0] left_red;
    logic [7:0] left_alpha;
    logic [7:0] right_blue;
    logic [7:0] right_green;
    logic [7:0] right_red;
    logic [7:0] right_alpha;
    logic       frame_end;
  } pdc_in_word_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
    logic [1:0] pixel_class;
    logic       images_identical;
    logic       frame_end_out;
  } pdc_out_word_t;

  typedef struct packed {
    logic [7:0]  tolerance;
    logic [23:0] below_colour;
    logic [23:0] above_colour;
  } pdc_cfg_t;

endpackage

`default_nettype wire

@@ rtl/pdc_if.sv @@
// Valid/ready channel interfaces for pixel input, result output and configuration.
// Depends on pdc_pkg for the word types.
`timescale 1ns / 1ps
`default_nettype none

interface pdc_in_if;
  import pdc_pkg::*;
  logic         valid;
  logic         ready;
  pdc_in_word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface pdc_out_if;
  import pdc_pkg::*;
  logic          valid;
  logic          ready;
  pdc_out_word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface pdc_cfg_if;
  import pdc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/pixel_diff_classifier.sv @@
// Top level of the pixel difference classifier: input register, datapath, result register.
// Depends on pdc_pkg, pdc_if, pdc_cfg_regs and pdc_datapath.
//
//   channel   direction  contents
//   in_bus    sink       left and right BGRA pixel, frame_end
//   out_bus   source     difference map BGRA pixel, class, identity flag, frame_end_out
//   cfg_bus   sink       register index and data, always ready
//
// Each word passes one input register and then one result register on its way to
// out_bus, and one word is taken every cycle while the output is drained. A stall
// on out_bus holds both stages and drops in_bus.ready once they are full. Reset
// clears both stages, loads the register defaults and sets the identity flag.
`timescale 1ns / 1ps
`default_nettype none

module pixel_diff_classifier (
  input  wire logic clk,
  input  wire logic rst_n,
  pdc_in_if.sink    in_bus,
  pdc_out_if.source out_bus,
  pdc_cfg_if.sink   cfg_bus
);
  import pdc_pkg::*;

  pdc_cfg_t      cfg;
  logic          s1_valid_r;
  pdc_in_word_t  s1_word_r;
  logic          o_valid_r;
  pdc_out_word_t o_word_r;
  logic          all_same_r;
  logic          all_same_nxt;
  pdc_out_word_t res_word;
  logic          same;
  logic          o_adv;
  logic          s1_adv;
  logic          in_ready;

  pdc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  pdc_datapath u_dp (
    .in_word         (s1_word_r),
    .cfg             (cfg),
    .all_same_so_far (all_same_r),
    .out_word        (res_word),
    .same            (same)
  );

  assign o_adv = !o_valid_r || out_bus.ready;
  assign s1_adv = s1_valid_r && o_adv;
  assign in_ready = !s1_valid_r || o_adv;
  assign in_bus.ready = in_ready;
  assign out_bus.valid = o_valid_r;
  assign out_bus.word = o_word_r;

  // The flag starts over after the last pixel of each frame.
  assign all_same_nxt = s1_word_r.frame_end ? 1'b1 : (all_same_r && same);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
      all_same_r <= 1'b1;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_bus.valid;
      end
      if (o_adv) begin
        o_valid_r <= s1_valid_r;
      end
      if (s1_adv) begin
        all_same_r <= all_same_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_bus.valid) begin
      s1_word_r <= in_bus.word;
    end
    if (s1_adv) begin
      o_word_r <= res_word;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pdc_cfg_regs.sv @@
// Configuration register file: tolerance and the two marker colours.
// Depends on pdc_pkg and pdc_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module pdc_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  pdc_cfg_if.sink            cfg_bus,
  output pdc_pkg::pdc_cfg_t  cfg
);
  import pdc_pkg::*;

  pdc_cfg_t cfg_r;
  pdc_cfg_t cfg_nxt;

  assign cfg_bus.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        CFG_TOLERANCE:    cfg_nxt.tolerance = cfg_bus.data[7:0];
        CFG_BELOW_COLOUR: cfg_nxt.below_colour = cfg_bus.data;
        CFG_ABOVE_COLOUR: cfg_nxt.above_colour = cfg_bus.data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tolerance <= TOLERANCE_RST;
      cfg_r.below_colour <= BELOW_COLOUR_RST;
      cfg_r.above_colour <= ABOVE_COLOUR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pdc_datapath.sv @@
// Per-pixel logic: channel differences, classification, gray level and colour select.
// Depends on pdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdc_datapath (
  input  wire pdc_pkg::pdc_in_word_t  in_word,
  input  wire pdc_pkg::pdc_cfg_t      cfg,
  input  wire logic                   all_same_so_far,
  output pdc_pkg::pdc_out_word_t      out_word,
  output logic                        same
);
  import pdc_pkg::*;

  logic [7:0]  d_blue, d_green, d_red, d_alpha;
  logic        bigger;
  logic [23:0] gray_sum;
  logic [7:0]  gray;
  logic [23:0] colour;
  pdc_class_t  cls;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    d_blue  = abs_diff(in_word.left_blue, in_word.right_blue);
    d_green = abs_diff(in_word.left_green, in_word.right_green);
    d_red   = abs_diff(in_word.left_red, in_word.right_red);
    d_alpha = abs_diff(in_word.left_alpha, in_word.right_alpha);

    same = (d_blue == 8'd0) && (d_green == 8'd0) && (d_red == 8'd0) && (d_alpha == 8'd0);
    bigger = (d_blue > cfg.tolerance) || (d_green > cfg.tolerance)
          || (d_red > cfg.tolerance) || (d_alpha > cfg.tolerance);

    gray_sum = 24'(GRAY_COEF_R) * 24'(in_word.left_red)
             + 24'(GRAY_COEF_G) * 24'(in_word.left_green)
             + 24'(GRAY_COEF_B) * 24'(in_word.left_blue);
    gray = gray_sum[23:16];

    priority if (same) begin
      colour = {gray, gray, gray};
      cls = CLS_IDENTICAL;
    end else if (bigger) begin
      colour = cfg.above_colour;
      cls = CLS_ABOVE;
    end else begin
      colour = cfg.below_colour;
      cls = CLS_BELOW;
    end

    out_word.out_blue = colour[7:0];
    out_word.out_green = colour[15:8];
    out_word.out_red = colour[23:16];
    out_word.out_alpha = OUT_ALPHA_VALUE;
    out_word.pixel_class = cls;
    out_word.images_identical = in_word.frame_end && all_same_so_far && same;
    out_word.frame_end_out = in_word.frame_end;
  end

endmodule

`default_nettype wire
